[hw/rtl/bcpd_pkg.sv]
// shared types, constants and palette for the bitmap cell pixel decoder
`timescale 1ns / 1ps
`default_nettype none
package bcpd_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUXILIARY  = 4'd3;

  localparam logic [3:0] RST_BACKGROUND = 4'd1;
  localparam logic [2:0] RST_BORDER     = 3'd3;
  localparam logic       RST_NORMAL     = 1'b1;
  localparam logic [3:0] RST_AUXILIARY  = 4'd0;

  localparam logic [2:0] LAST_PIXEL_IDX = 3'd7;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic [3:0] cell_colour;
    logic [4:0] column;
    logic [7:0] row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [7:0]      pattern;
    logic            multi;
    logic [3:0][3:0] choice;
    logic [7:0]      x0;
    logic [7:0]      row;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic rgb_t palette(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd0,   8'd0,   8'd0};
      4'd1:    c = '{8'd255, 8'd255, 8'd255};
      4'd2:    c = '{8'd148, 8'd23,  8'd1};
      4'd3:    c = '{8'd82,  8'd198, 8'd212};
      4'd4:    c = '{8'd144, 8'd28,  8'd204};
      4'd5:    c = '{8'd81,  8'd190, 8'd8};
      4'd6:    c = '{8'd49,  8'd26,  8'd213};
      4'd7:    c = '{8'd196, 8'd215, 8'd28};
      4'd8:    c = '{8'd163, 8'd81,  8'd0};
      4'd9:    c = '{8'd208, 8'd176, 8'd22};
      4'd10:   c = '{8'd233, 8'd121, 8'd105};
      4'd11:   c = '{8'd132, 8'd243, 8'd255};
      4'd12:   c = '{8'd221, 8'd115, 8'd255};
      4'd13:   c = '{8'd142, 8'd246, 8'd79};
      4'd14:   c = '{8'd133, 8'd112, 8'd255};
      4'd15:   c = '{8'd242, 8'd255, 8'd84};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bcpd_front.sv]
// front end: configuration registers, screen clipping and colour choice per byte
`timescale 1ns / 1ps
`default_nettype none
module bcpd_front
  import bcpd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 192
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_item_t              item,
  output q_entry_t                   entry,
  output logic                       on_screen
);

  localparam logic [9:0] SW = 10'(SCREEN_WIDTH);
  localparam logic [9:0] SH = 10'(SCREEN_HEIGHT);

  logic [3:0] background_r, background_nxt;
  logic [2:0] border_r, border_nxt;
  logic       normal_r, normal_nxt;
  logic [3:0] auxiliary_r, auxiliary_nxt;
  logic [3:0] cell_idx;
  logic [9:0] x_end;

  always_comb begin
    background_nxt = background_r;
    border_nxt     = border_r;
    normal_nxt     = normal_r;
    auxiliary_nxt  = auxiliary_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BACKGROUND: background_nxt = cfg_data;
        CFG_BORDER:     border_nxt     = cfg_data[2:0];
        CFG_NORMAL:     normal_nxt     = cfg_data[0];
        CFG_AUXILIARY:  auxiliary_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      background_r <= RST_BACKGROUND;
      border_r     <= RST_BORDER;
      normal_r     <= RST_NORMAL;
      auxiliary_r  <= RST_AUXILIARY;
    end else begin
      background_r <= background_nxt;
      border_r     <= border_nxt;
      normal_r     <= normal_nxt;
      auxiliary_r  <= auxiliary_nxt;
    end
  end

  assign cell_idx  = {1'b0, item.cell_colour[2:0]};
  assign x_end     = {2'b00, item.column, 3'b000} + 10'd7;
  assign on_screen = (x_end < SW) && ({2'b00, item.row} < SH);

  always_comb begin
    entry.pattern = item.pattern_byte;
    entry.multi   = item.cell_colour[3];
    entry.x0      = {item.column, 3'b000};
    entry.row     = item.row;
    if (item.cell_colour[3]) begin
      entry.choice[0] = background_r;
      entry.choice[1] = {1'b0, border_r};
      entry.choice[2] = cell_idx;
      entry.choice[3] = auxiliary_r;
    end else if (normal_r) begin
      entry.choice[0] = background_r;
      entry.choice[1] = cell_idx;
      entry.choice[2] = 4'd0;
      entry.choice[3] = 4'd0;
    end else begin
      entry.choice[0] = cell_idx;
      entry.choice[1] = background_r;
      entry.choice[2] = 4'd0;
      entry.choice[3] = 4'd0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bcpd_queue.sv]
// short queue of classified bytes between front and back end
`timescale 1ns / 1ps
`default_nettype none
module bcpd_queue
  import bcpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_status_t     status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == DEPTH_C);
  assign status.empty = (count_r == '0);
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!status.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

[hw/rtl/bcpd_back.sv]
// back end: serializes one byte into eight palette pixels through an output register
`timescale 1ns / 1ps
`default_nettype none
module bcpd_back
  import bcpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_entry_t  head,
  input  wire q_status_t status,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  q_entry_t   cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       advance, take, last;
  logic [1:0] pair_sel, code;
  logic [2:0] bit_sel;
  rgb_t       rgb;

  assign advance = !out_valid_r || out_ready;
  assign take    = advance && busy_r;
  assign last    = (cnt_r == LAST_PIXEL_IDX);
  assign pop     = !status.empty && (!busy_r || (take && last));

  assign pair_sel = ~cnt_r[2:1];
  assign bit_sel  = ~cnt_r;

  always_comb begin
    if (cur_r.multi) begin
      code = {cur_r.pattern[{pair_sel, 1'b1}], cur_r.pattern[{pair_sel, 1'b0}]};
    end else begin
      code = {1'b0, cur_r.pattern[bit_sel]};
    end
    rgb = palette(cur_r.choice[code]);
  end

  always_comb begin
    cur_nxt       = pop ? head : cur_r;
    busy_nxt      = busy_r;
    cnt_nxt       = take ? 3'(cnt_r + 1'b1) : cnt_r;
    out_valid_nxt = advance ? busy_r : out_valid_r;
    out_data_nxt  = out_data_r;
    if (pop) begin
      busy_nxt = 1'b1;
    end else if (take && last) begin
      busy_nxt = 1'b0;
    end
    if (take) begin
      out_data_nxt.pixel_x    = cur_r.x0 + {5'd0, cnt_r};
      out_data_nxt.pixel_y    = cur_r.row;
      out_data_nxt.red        = rgb.r;
      out_data_nxt.green      = rgb.g;
      out_data_nxt.blue       = rgb.b;
      out_data_nxt.last_pixel = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd0) |-> busy_r)
    else $error("pixel counter running while idle");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> ($past(cnt_r) == LAST_PIXEL_IDX))
    else $error("byte dropped before its eighth pixel");

  a_last_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last) |=> (cnt_r == 3'd0))
    else $error("counter not wrapped after eighth pixel");

endmodule
`default_nettype wire

[hw/rtl/bitmap_cell_pixel_decode.sv]
// an accepted byte passes the queue and the back end byte register on its way to out_
// throughput: one pixel per cycle while out_ready is high, set by the back end serializer
// a two-entry queue lets the input accept while the back end is still emitting pixels
// off-screen bytes are accepted whenever in_ready is high and produce no transfer
// reset: configuration returns to its reset values, queue and output register are emptied
`timescale 1ns / 1ps
`default_nettype none
module bitmap_cell_pixel_decode
  import bcpd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 192
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  q_entry_t  entry, head;
  q_status_t status;
  logic      on_screen, push, pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !status.full;
  assign push      = in_valid && in_ready && on_screen;

  bcpd_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (in_data),
    .entry    (entry),
    .on_screen(on_screen)
  );

  bcpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(entry),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  bcpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .status   (status),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
